### sv/header_length_frame_deframer_unit_assert.svh
// Assertion macros shared by the deframer modules.
`ifndef HEADER_LENGTH_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define HEADER_LENGTH_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define HLFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define HLFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### sv/hlfd_pkg.sv
`default_nettype none

package hlfd_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_OUT_W = 9;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HDR = 1'b1;

    localparam logic [BYTE_W-1:0] FIRST_HDR_RESET = 8'h08;
    localparam logic [BYTE_W-1:0] SECOND_HDR_RESET = 8'h06;

    // Fixed bytes of a frame that are not counted by the length field.
    localparam int FRAME_OVERHEAD = 7;
    // Index of the length low byte, where an oversized length is reported.
    localparam int LEN_LOW_POS = 3;

    typedef enum logic [2:0] {
        PH_HUNT_FIRST  = 3'd0,
        PH_HUNT_SECOND = 3'd1,
        PH_LEN_HIGH    = 3'd2,
        PH_LEN_LOW     = 3'd3,
        PH_BODY        = 3'd4
    } t_phase;

    typedef struct packed {
        logic                 hit;
        logic [BYTE_W-1:0]    data;
        logic [POS_OUT_W-1:0] pos;
        logic                 last;
        logic                 err;
    } t_frm_res;

endpackage

`default_nettype wire

### sv/hlfd_rx_if.sv
`default_nettype none

interface hlfd_rx_if
    import hlfd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### sv/hlfd_frm_if.sv
`default_nettype none

interface hlfd_frm_if
    import hlfd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    frame_byte;
    logic [POS_OUT_W-1:0] byte_position;
    logic                 frame_end;
    logic                 length_error;

    modport source (
        output valid, output frame_byte, output byte_position,
        output frame_end, output length_error, input ready
    );
    modport sink (
        input valid, input frame_byte, input byte_position,
        input frame_end, input length_error, output ready
    );
endinterface

`default_nettype wire

### sv/hlfd_parse.sv
`default_nettype none

`include "header_length_frame_deframer_unit_assert.svh"

module hlfd_parse
    import hlfd_pkg::*;
#(
    parameter int FRAME_MAX = 512
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [BYTE_W-1:0] i_first_hdr,
    input  wire logic [BYTE_W-1:0] i_second_hdr,
    output t_frm_res               o_res
);

    localparam int POS_W = $clog2(FRAME_MAX);
    localparam int TOT_W = 2 * BYTE_W + 1;
    localparam logic [TOT_W-1:0] FRAME_MAX_T = TOT_W'(FRAME_MAX);
    localparam logic [TOT_W-1:0] OVERHEAD_T = TOT_W'(FRAME_OVERHEAD);

    t_phase r_phase, n_phase;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;
    logic [POS_W-1:0]  r_pos, n_pos;
    // Index of the last byte of the current frame (length + 6).
    logic [POS_W-1:0]  r_last, n_last;

    logic [TOT_W-1:0]     total;
    logic [TOT_W-1:0]     last_full;
    logic [POS_W+8:0]     pos_ext;

    assign total = {1'b0, r_len_hi, i_byte} + OVERHEAD_T;
    assign last_full = total - TOT_W'(1);
    assign pos_ext = {9'd0, r_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT_FIRST;
            r_len_hi <= '0;
            r_pos <= '0;
            r_last <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_len_hi <= n_len_hi;
            r_pos <= n_pos;
            r_last <= n_last;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_len_hi = r_len_hi;
        n_pos = r_pos;
        n_last = r_last;
        o_res.hit = 1'b1;
        o_res.data = i_byte;
        o_res.pos = pos_ext[POS_OUT_W-1:0];
        o_res.last = 1'b0;
        o_res.err = 1'b0;
        unique case (r_phase)
            PH_HUNT_SECOND: begin
                if (i_byte == i_second_hdr) begin
                    n_phase = PH_LEN_HIGH;
                    n_pos = r_pos + 1'b1;
                end else begin
                    o_res.hit = 1'b0;
                end
            end
            PH_LEN_HIGH: begin
                n_len_hi = i_byte;
                n_phase = PH_LEN_LOW;
                n_pos = r_pos + 1'b1;
            end
            PH_LEN_LOW: begin
                if (total > FRAME_MAX_T) begin
                    o_res.last = 1'b1;
                    o_res.err = 1'b1;
                    n_phase = PH_HUNT_FIRST;
                    n_len_hi = '0;
                    n_pos = '0;
                end else begin
                    n_last = last_full[POS_W-1:0];
                    n_phase = PH_BODY;
                    n_pos = r_pos + 1'b1;
                end
            end
            PH_BODY: begin
                if (r_pos >= r_last) begin
                    o_res.last = 1'b1;
                    n_phase = PH_HUNT_FIRST;
                    n_len_hi = '0;
                    n_pos = '0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            default: begin
                // Unused codes behave as hunting for the first header byte.
                n_len_hi = '0;
                if (i_byte == i_first_hdr) begin
                    n_phase = PH_HUNT_SECOND;
                    n_pos = POS_W'(1);
                end else begin
                    o_res.hit = 1'b0;
                    n_phase = PH_HUNT_FIRST;
                    n_pos = '0;
                end
            end
        endcase
    end

    `HLFD_ASSERT(a_hunt_pos_zero, r_phase == PH_HUNT_FIRST |-> r_pos == '0, "hunt with nonzero position")
    `HLFD_ASSERT(a_body_in_frame, r_phase == PH_BODY |-> (r_pos >= POS_W'(4)) && (r_pos <= r_last), "body position outside frame")
    `HLFD_ASSERT(a_len_low_pos, r_phase == PH_LEN_LOW |-> r_pos == POS_W'(LEN_LOW_POS), "length low byte at wrong position")

endmodule

`default_nettype wire

### sv/header_length_frame_deframer_unit.sv
// Header and length prefixed frame deframer.
//
// i_rx carries received bytes, one per transaction. The block hunts for the
// first header byte, waits for the second, takes a big-endian 16-bit length
// and then passes the frame bytes through. o_frm carries every byte of a
// frame (headers and length included) with its index in the frame;
// frame_end marks the last byte, or the length low byte when the length
// would make the frame exceed FRAME_MAX, in which case length_error is set
// too. Bytes dropped while hunting give no transaction on o_frm.
// Results are registered, and one byte is taken every cycle while o_frm does
// not stall: the parse state and the result register update together from a
// single compare and counter step. The user must write the header values
// through the i_cfg_* port only while idle; the block does not enforce it.
// Reset clears the parser to hunting, empties the result register and loads
// the header registers with 0x08 and 0x06. When o_frm stalls, the result
// register holds and i_rx.ready drops until the held result is taken.
`default_nettype none

`include "header_length_frame_deframer_unit_assert.svh"

module header_length_frame_deframer_unit
    import hlfd_pkg::*;
#(
    parameter int FRAME_MAX = 512
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    hlfd_rx_if.sink                   i_rx,
    hlfd_frm_if.source                o_frm
);

    logic [BYTE_W-1:0] r_first_hdr;
    logic [BYTE_W-1:0] r_second_hdr;
    logic              r_valid;
    t_frm_res          r_res;
    t_frm_res          parse_res;
    logic              take;

    assign i_rx.ready = !r_valid || o_frm.ready;
    assign take = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_hdr <= FIRST_HDR_RESET;
            r_second_hdr <= SECOND_HDR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_HDR: r_first_hdr <= i_cfg_data;
                CFG_SECOND_HDR: r_second_hdr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hlfd_parse #(
        .FRAME_MAX(FRAME_MAX)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_rx.rx_byte),
        .i_first_hdr (r_first_hdr),
        .i_second_hdr(r_second_hdr),
        .o_res       (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= parse_res.hit;
        end else if (o_frm.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= parse_res;
        end
    end

    assign o_frm.valid = r_valid;
    assign o_frm.frame_byte = r_res.data;
    assign o_frm.byte_position = r_res.pos;
    assign o_frm.frame_end = r_res.last;
    assign o_frm.length_error = r_res.err;

    `HLFD_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n) |-> !r_valid, "result valid right after reset")
    `HLFD_ASSERT(a_err_at_len_low, r_valid && r_res.err |-> r_res.last && (r_res.pos == POS_OUT_W'(LEN_LOW_POS)), "length error off the length low byte")
    `HLFD_ASSERT(a_empty_ready, !r_valid |-> i_rx.ready, "input blocked with empty result register")

endmodule

`default_nettype wire

### verif/header_length_frame_deframer_unit_tb.sv
`default_nettype none

module header_length_frame_deframer_unit_tb;
    import hlfd_pkg::*;

    localparam int FRAME_MAX = 512;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int HOLD_FRAME_LEN = 100;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_data;

    hlfd_rx_if  rx_if ();
    hlfd_frm_if frm_if ();

    header_length_frame_deframer_unit #(
        .FRAME_MAX(FRAME_MAX)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_rx(rx_if.sink),
        .o_frm(frm_if.source)
    );

    always #4 i_clk = ~i_clk;

    // Deframer state as the hardware should hold it.
    t_phase            parse_ph;
    logic [15:0]       body_len;
    logic [9:0]        pos_cnt;
    logic [BYTE_W-1:0] first_hdr;
    logic [BYTE_W-1:0] second_hdr;

    logic [BYTE_W-1:0] rx_byte_q [$];
    t_frm_res          frame_beat_q [$];
    t_frm_res          want_beat;

    int bytes_queued = 0;
    int fail_count = 0;
    int stall_cycles = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int hold_left = 0;
    bit drv_busy = 1'b0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    logic [BYTE_W-1:0] opening_seq [$] = '{
        // Bytes dropped while hunting, the second header among them.
        8'h00, 8'hFF, 8'h06,
        // A repeated first header while waiting is dropped, not a restart.
        8'h08, 8'h08, 8'h00, 8'h06,
        // Zero length: three body bytes, the last one ends the frame.
        8'h00, 8'h00, 8'hFF, 8'h00, 8'h80,
        // One past the largest length, then the largest length field.
        8'h08, 8'h06, 8'h01, 8'hFA,
        8'h08, 8'h06, 8'hFF, 8'hFF,
        8'h08, 8'h06, 8'h00, 8'h01, 8'h55, 8'hAA, 8'h01, 8'hFE
    };

    task automatic restart_hunt();
        parse_ph = PH_HUNT_FIRST;
        body_len = '0;
        pos_cnt = '0;
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        t_frm_res res;
        int       frame_total;
        res = '0;
        res.data = b;
        res.pos = pos_cnt[POS_OUT_W-1:0];
        frame_total = int'(body_len) + FRAME_OVERHEAD;
        case (parse_ph)
            PH_HUNT_SECOND: begin
                res.hit = (b == second_hdr);
                if (res.hit) begin
                    pos_cnt = pos_cnt + 1'b1;
                    parse_ph = PH_LEN_HIGH;
                end
            end
            PH_LEN_HIGH: begin
                res.hit = 1'b1;
                body_len = {b, 8'h00};
                pos_cnt = pos_cnt + 1'b1;
                parse_ph = PH_LEN_LOW;
            end
            PH_LEN_LOW: begin
                res.hit = 1'b1;
                body_len[7:0] = b;
                frame_total = int'(body_len) + FRAME_OVERHEAD;
                if (frame_total > FRAME_MAX) begin
                    res.last = 1'b1;
                    res.err = 1'b1;
                    restart_hunt();
                end else begin
                    pos_cnt = pos_cnt + 1'b1;
                    parse_ph = PH_BODY;
                end
            end
            PH_BODY: begin
                res.hit = 1'b1;
                if (int'(pos_cnt) + 1 >= frame_total) begin
                    res.last = 1'b1;
                    restart_hunt();
                end else begin
                    pos_cnt = pos_cnt + 1'b1;
                end
            end
            default: begin
                res.hit = (b == first_hdr);
                res.pos = '0;
                restart_hunt();
                if (res.hit) begin
                    pos_cnt = 10'd1;
                    parse_ph = PH_HUNT_SECOND;
                end
            end
        endcase
        if (res.hit)
            frame_beat_q.push_back(res);
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        rx_byte_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input int unsigned len);
        logic [BYTE_W-1:0] body;
        queue_byte(first_hdr);
        queue_byte(second_hdr);
        queue_byte(len[15:8]);
        queue_byte(len[7:0]);
        if (len + FRAME_OVERHEAD <= FRAME_MAX) begin
            repeat (len + FRAME_OVERHEAD - 4) begin
                body = BYTE_W'($urandom_range(0, 255));
                queue_byte(body);
            end
        end
    endtask

    // Mostly frames, some with too large a length, the rest stray bytes and broken header pairs.
    task automatic queue_traffic(input int n_items);
        int                stop_at;
        int                pick;
        int unsigned       len;
        logic [BYTE_W-1:0] junk;
        stop_at = bytes_queued + n_items;
        while (bytes_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    len = $urandom_range(0, 24);
                else if (pick < 90)
                    len = $urandom_range(25, 200);
                else if (pick < 98)
                    len = $urandom_range(FRAME_MAX - FRAME_OVERHEAD + 1, 65535);
                else
                    len = FRAME_MAX - FRAME_OVERHEAD + 1;
                queue_frame(len);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6)) begin
                    junk = BYTE_W'($urandom_range(0, 255));
                    queue_byte(junk);
                end
            end else begin
                queue_byte(first_hdr);
                repeat ($urandom_range(1, 3)) begin
                    junk = BYTE_W'($urandom_range(0, 255));
                    if (junk == second_hdr)
                        junk = ~junk;
                    queue_byte(junk);
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (rx_byte_q.size() != 0 || drv_busy || frame_beat_q.size() != 0)
            @(negedge i_clk);
        // A dropped byte leaves nothing to wait for, so give the block time to settle.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_header(input logic [CFG_IDX_W-1:0] idx,
                                input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FIRST_HDR)
            first_hdr = val;
        else
            second_hdr = val;
    endtask

    // Byte source: holds the current byte until its transaction completes.
    always @(negedge i_clk) begin
        if (!i_rst_n || drv_busy) begin
        end else if (src_gap > 0) begin
            src_gap--;
            rx_if.valid <= 1'b0;
        end else if (rx_byte_q.size() != 0) begin
            rx_if.rx_byte <= rx_byte_q.pop_front();
            rx_if.valid <= 1'b1;
            drv_busy = 1'b1;
            if (idle_on && $urandom_range(0, 99) < 12)
                src_gap = $urandom_range(1, 4);
        end else begin
            rx_if.valid <= 1'b0;
        end
    end

    // Frame sink with short random stalls and one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (!i_rst_n) begin
            frm_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            frm_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            frm_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 12) begin
            sink_gap = $urandom_range(0, 3);
            frm_if.ready <= 1'b0;
        end else begin
            frm_if.ready <= 1'b1;
        end
    end

    // Results are checked before the byte taken at the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n && frm_if.valid && frm_if.ready) begin
            if (frame_beat_q.size() == 0) begin
                $error("unexpected frame_byte %0h at byte_position %0d",
                       frm_if.frame_byte, frm_if.byte_position);
                fail_count++;
            end else begin
                want_beat = frame_beat_q.pop_front();
                if (frm_if.frame_byte !== want_beat.data) begin
                    $error("frame_byte: expected %0h, got %0h",
                           want_beat.data, frm_if.frame_byte);
                    fail_count++;
                end
                if (frm_if.byte_position !== want_beat.pos) begin
                    $error("byte_position: expected %0d, got %0d",
                           want_beat.pos, frm_if.byte_position);
                    fail_count++;
                end
                if (frm_if.frame_end !== want_beat.last) begin
                    $error("frame_end: expected %0b, got %0b",
                           want_beat.last, frm_if.frame_end);
                    fail_count++;
                end
                if (frm_if.length_error !== want_beat.err) begin
                    $error("length_error: expected %0b, got %0b",
                           want_beat.err, frm_if.length_error);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && rx_if.valid && rx_if.ready) begin
            deframe_byte(rx_if.rx_byte);
            drv_busy = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (frm_if.valid && frm_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("header_length_frame_deframer_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_FIRST_HDR;
        i_cfg_data = '0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = '0;
        frm_if.ready = 1'b0;
        first_hdr = FIRST_HDR_RESET;
        second_hdr = SECOND_HDR_RESET;
        restart_hunt();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_seq[i])
            queue_byte(opening_seq[i]);
        queue_traffic(110);
        wait_drained();

        write_header(CFG_FIRST_HDR, 8'h00);
        write_header(CFG_SECOND_HDR, 8'hFF);
        // The sink stops while a long frame is offered, so the input backs up.
        hold_req = 1'b1;
        queue_frame(HOLD_FRAME_LEN);
        queue_traffic(60);
        wait_drained();

        write_header(CFG_FIRST_HDR, 8'hFF);
        write_header(CFG_SECOND_HDR, 8'h00);
        queue_traffic(120);
        wait_drained();

        write_header(CFG_FIRST_HDR, 8'h5A);
        write_header(CFG_SECOND_HDR, 8'h5A);
        queue_traffic(80);
        wait_drained();

        write_header(CFG_FIRST_HDR, BYTE_W'($urandom_range(0, 255)));
        write_header(CFG_SECOND_HDR, BYTE_W'($urandom_range(0, 255)));
        idle_on = 1'b0;
        queue_traffic(130);
        wait_drained();

        if (fail_count == 0) begin
            $display("header_length_frame_deframer_unit: match");
        end else begin
            $display("header_length_frame_deframer_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+sv
sv/hlfd_pkg.sv
sv/hlfd_rx_if.sv
sv/hlfd_frm_if.sv
sv/hlfd_parse.sv
sv/header_length_frame_deframer_unit.sv
verif/header_length_frame_deframer_unit_tb.sv
